[rtl/pgch_pkg.sv]
// ----------------------------------------------------------------------------
// pgch_pkg: shared types and constants of the grid cell hash
// Word type, mix constants, the dimension limits and the control word
// that the sequencer sends to the round cells.
// ----------------------------------------------------------------------------
package pgch_pkg;

	typedef logic [31:0] word_t;

	localparam int DIMS_MAX = 16;
	localparam int DIMS_W   = 5;
	localparam int ROUNDS   = 10;
	localparam int ROUND_W  = 4;

	localparam logic [DIMS_W-1:0] DIMS_RESET = DIMS_W'(4);

	localparam word_t KEY0 = 32'h4edbf6fa;
	localparam word_t KEY1 = 32'h6aa1107f;
	localparam word_t MUL0 = 32'hCD9E8D57;
	localparam word_t MUL1 = 32'hD2511F53;

	typedef struct packed {
		logic load;
		logic step;
	} cell_ctrl_t;

endpackage

[rtl/pgch_cell.sv]
// ----------------------------------------------------------------------------
// pgch_cell: one round cell of the mix
// Holds an even and an odd word and its own Weyl key. Each round the low half
// of odd*mul becomes the new even word, and the mixed high half is handed to
// the neighbor cell, which takes it as its new odd word.
// ----------------------------------------------------------------------------
module pgch_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  pgch_pkg::cell_ctrl_t ctrl,
	input  pgch_pkg::word_t    mul,
	input  pgch_pkg::word_t    key_base,
	input  pgch_pkg::word_t    even_in,
	input  pgch_pkg::word_t    odd_in,
	input  pgch_pkg::word_t    hi_in,
	output pgch_pkg::word_t    even,
	output pgch_pkg::word_t    odd,
	output pgch_pkg::word_t    hi_out
);
	import pgch_pkg::*;

	word_t       even_q;
	word_t       odd_q;
	word_t       key_q;
	logic [63:0] prod;

	assign prod   = 64'(odd_q) * 64'(mul);
	assign hi_out = prod[63:32] ^ key_q ^ even_q;
	assign even   = even_q;
	assign odd    = odd_q;

	// The key register walks base, 2*base, ... so round r sees base*r.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (ctrl.load) begin
			key_q <= key_base;
		end else if (ctrl.step) begin
			key_q <= key_q + key_base;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			even_q <= even_in;
			odd_q  <= odd_in;
		end else if (ctrl.step) begin
			even_q <= prod[31:0];
			odd_q  <= hi_in;
		end
	end

endmodule

[rtl/philox_grid_cell_hash.sv]
// ----------------------------------------------------------------------------
// philox_grid_cell_hash: grid cell coordinate hash
// Prefix sums each group of four coordinates, mixes the four words through
// ten rounds in a ring of two multiplier cells and XORs two of them into the
// hash accumulators. The hash word goes out after the last group of a vector.
// ----------------------------------------------------------------------------
// A hash word follows an accepted word only when it closes a vector (last group).
// A group passes a prefix step, a load step, ten rounds through the two cell
// multipliers and an accumulate step; no new group is taken until it is done.
// A finished hash may wait in the output register while the next group runs.
// Reset clears the sequencer, vector state and out_valid; dims resets to 4.
module philox_grid_cell_hash (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wen,
	input  logic [pgch_pkg::DIMS_W-1:0]       cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [31:0]                coord0,
	input  logic signed [31:0]                coord1,
	input  logic signed [31:0]                coord2,
	input  logic signed [31:0]                coord3,
	output logic                              out_valid,
	input  logic                              out_stall,
	output pgch_pkg::word_t                   hash_a,
	output pgch_pkg::word_t                   hash_b
);
	import pgch_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_ROUND,
		ST_DONE
	} state_t;

	state_t             state_q;
	logic [DIMS_W-1:0]  dims_q;
	logic [1:0]         gi_q;
	word_t              rs_q;
	word_t              acc_a_q;
	word_t              acc_b_q;
	word_t              p0_q, p1_q, p2_q, p3_q;
	logic [3:0]         lanes_q;
	logic               last_q;
	logic [ROUND_W-1:0] round_q;
	logic               out_valid_q;
	word_t              hash_a_q;
	word_t              hash_b_q;

	logic [DIMS_W-1:0]  eff_dims;
	logic [2:0]         groups;
	logic [3:0]         lane_ok;
	word_t              m0, m1, m2, m3, m01, m23;
	logic               accept;
	logic               out_free;
	cell_ctrl_t         ctrl;
	word_t              w0, w1, w2, w3;
	word_t              c0_even, c0_odd, c0_hi, c1_even, c1_odd, c1_hi;

	always_comb begin
		if (dims_q == '0) begin
			eff_dims = DIMS_W'(1);
		end else if (dims_q > DIMS_W'(DIMS_MAX)) begin
			eff_dims = DIMS_W'(DIMS_MAX);
		end else begin
			eff_dims = dims_q;
		end
	end

	assign groups = 3'((6'(eff_dims) + 6'd3) >> 2);

	// Lane i of group g holds dimension 4*g + i.
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			lane_ok[i] = ({1'b0, gi_q, 2'(i)} < eff_dims);
		end
	end

	assign m0  = lane_ok[0] ? word_t'(coord0) : '0;
	assign m1  = lane_ok[1] ? word_t'(coord1) : '0;
	assign m2  = lane_ok[2] ? word_t'(coord2) : '0;
	assign m3  = lane_ok[3] ? word_t'(coord3) : '0;
	assign m01 = m0 + m1;
	assign m23 = m2 + m3;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign ctrl.load = (state_q == ST_LOAD);
	assign ctrl.step = (state_q == ST_ROUND);

	assign w0 = lanes_q[0] ? rs_q + p0_q : '0;
	assign w1 = lanes_q[1] ? rs_q + p1_q : '0;
	assign w2 = lanes_q[2] ? rs_q + p2_q : '0;
	assign w3 = lanes_q[3] ? rs_q + p3_q : '0;

	pgch_cell u_cell0 (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.mul      (MUL0),
		.key_base (KEY0),
		.even_in  (w0),
		.odd_in   (w1),
		.hi_in    (c1_hi),
		.even     (c0_even),
		.odd      (c0_odd),
		.hi_out   (c0_hi)
	);

	pgch_cell u_cell1 (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.mul      (MUL1),
		.key_base (KEY1),
		.even_in  (w2),
		.odd_in   (w3),
		.hi_in    (c0_hi),
		.even     (c1_even),
		.odd      (c1_odd),
		.hi_out   (c1_hi)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			p0_q    <= m0;
			p1_q    <= m01;
			p2_q    <= m01 + m2;
			p3_q    <= m01 + m23;
			lanes_q <= lane_ok;
			last_q  <= ({1'b0, gi_q} + 3'd1 >= groups);
		end
		if (state_q == ST_DONE && last_q && out_free) begin
			hash_a_q <= acc_a_q ^ c0_even;
			hash_b_q <= acc_b_q ^ c0_odd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			dims_q      <= DIMS_RESET;
			gi_q        <= '0;
			rs_q        <= '0;
			acc_a_q     <= '0;
			acc_b_q     <= '0;
			round_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				dims_q <= cfg_wdata;
			end
			if (state_q == ST_DONE && last_q && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					// Invalid lanes add zero, so the whole group sum is p3.
					rs_q    <= rs_q + p3_q;
					round_q <= ROUND_W'(1);
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					if (round_q == ROUND_W'(ROUNDS)) begin
						state_q <= ST_DONE;
					end else begin
						round_q <= round_q + ROUND_W'(1);
					end
				end
				ST_DONE: begin
					if (!last_q) begin
						acc_a_q <= acc_a_q ^ c0_even;
						acc_b_q <= acc_b_q ^ c0_odd;
						gi_q    <= gi_q + 2'd1;
						state_q <= ST_IDLE;
					end else if (out_free) begin
						acc_a_q     <= '0;
						acc_b_q     <= '0;
						rs_q        <= '0;
						gi_q        <= '0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign hash_a    = hash_a_q;
	assign hash_b    = hash_b_q;

	// The words left in cell 1 are not part of the hash.
	word_t unused_xor;
	assign unused_xor = c1_even ^ c1_odd;

	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_LOAD))
		else $error("accepted word did not start a load");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE && last_q))
		else $error("hash word raised outside the last group's finish");

	a_clear_after_hash: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && last_q && out_free) |=>
			(rs_q == '0 && gi_q == '0 && acc_a_q == '0 && acc_b_q == '0))
		else $error("vector state not cleared after hash word");

	a_round_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND) |-> (round_q >= ROUND_W'(1) && round_q <= ROUND_W'(ROUNDS)))
		else $error("round counter out of range");

endmodule

[tb/tb_philox_grid_cell_hash.sv]
// ----------------------------------------------------------------------------
// tb_philox_grid_cell_hash: self-checking bench for the grid cell hash
// Drives groups of four coordinates under several dimension counts, predicts
// every hash word with a behavioral copy of the prefix sum and round mix, and
// compares each delivered hash word with the oldest prediction.
// ----------------------------------------------------------------------------

class cell_hash_predictor;

	logic [pgch_pkg::DIMS_W-1:0] dims_reg;
	pgch_pkg::word_t prefix;
	pgch_pkg::word_t acc_a;
	pgch_pkg::word_t acc_b;
	int unsigned group_idx;
	pgch_pkg::word_t pending_hash_a[$];
	pgch_pkg::word_t pending_hash_b[$];
	int unsigned mismatches;
	int unsigned words_seen;

	function new();
		dims_reg = pgch_pkg::DIMS_RESET;
		prefix = '0;
		acc_a = '0;
		acc_b = '0;
		group_idx = 0;
		mismatches = 0;
		words_seen = 0;
	endfunction

	function void set_dims(logic [pgch_pkg::DIMS_W-1:0] value);
		dims_reg = value;
	endfunction

	function int unsigned pending();
		return pending_hash_a.size();
	endfunction

	function void take_group(pgch_pkg::word_t c0, pgch_pkg::word_t c1,
			pgch_pkg::word_t c2, pgch_pkg::word_t c3);
		pgch_pkg::word_t lane[4];
		pgch_pkg::word_t coord[4];
		pgch_pkg::word_t n0, n1, n2, n3;
		logic [63:0] p0, p1;
		int unsigned eff;
		int unsigned groups;
		coord[0] = c0;
		coord[1] = c1;
		coord[2] = c2;
		coord[3] = c3;
		eff = dims_reg;
		if (eff == 0)
			eff = 1;
		if (eff > pgch_pkg::DIMS_MAX)
			eff = pgch_pkg::DIMS_MAX;
		groups = (eff + 3) / 4;
		for (int i = 0; i < 4; i++) begin
			if (group_idx < groups && group_idx * 4 + i < eff) begin
				prefix = prefix + coord[i];
				lane[i] = prefix;
			end else begin
				lane[i] = '0;
			end
		end
		for (int r = 1; r <= pgch_pkg::ROUNDS; r++) begin
			p0 = {32'd0, lane[1]} * {32'd0, pgch_pkg::MUL0};
			p1 = {32'd0, lane[3]} * {32'd0, pgch_pkg::MUL1};
			n0 = p0[31:0];
			n2 = p1[31:0];
			n3 = p0[63:32] ^ pgch_pkg::word_t'(pgch_pkg::KEY0 * r) ^ lane[0];
			n1 = p1[63:32] ^ pgch_pkg::word_t'(pgch_pkg::KEY1 * r) ^ lane[2];
			lane[0] = n0;
			lane[1] = n1;
			lane[2] = n2;
			lane[3] = n3;
		end
		acc_a ^= lane[0];
		acc_b ^= lane[1];
		if (group_idx + 1 >= groups) begin
			pending_hash_a.push_back(acc_a);
			pending_hash_b.push_back(acc_b);
			prefix = '0;
			acc_a = '0;
			acc_b = '0;
			group_idx = 0;
		end else begin
			group_idx++;
		end
	endfunction

	function void check_hash(pgch_pkg::word_t got_a, pgch_pkg::word_t got_b);
		pgch_pkg::word_t want_a;
		pgch_pkg::word_t want_b;
		words_seen++;
		if (pending_hash_a.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("hash word %0d arrived with none predicted: hash_a %h hash_b %h",
					words_seen, got_a, got_b);
			return;
		end
		want_a = pending_hash_a.pop_front();
		want_b = pending_hash_b.pop_front();
		if (got_a !== want_a || got_b !== want_b) begin
			mismatches++;
			if (mismatches <= 10)
				$display("hash word %0d: hash_a exp %h got %h, hash_b exp %h got %h",
					words_seen, want_a, got_a, want_b, got_b);
		end
	endfunction

endclass

module tb_philox_grid_cell_hash;

	localparam int unsigned RANDOM_GROUPS = 1730;
	localparam int unsigned QUIET_GROUPS  = 250;
	localparam int unsigned DRAIN_CYCLES  = 40;
	localparam int unsigned HOLD_CYCLES   = 400;
	localparam int unsigned CYCLE_LIMIT   = 400000;

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_wen = 1'b0;
	logic [pgch_pkg::DIMS_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [31:0] coord0 = '0;
	logic signed [31:0] coord1 = '0;
	logic signed [31:0] coord2 = '0;
	logic signed [31:0] coord3 = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	pgch_pkg::word_t hash_a;
	pgch_pkg::word_t hash_b;

	cell_hash_predictor hasher = new();

	bit idle_on = 1'b1;
	bit hold_req = 1'b0;
	bit offering = 1'b0;
	int unsigned groups_sent = 0;
	int unsigned cycles = 0;

	philox_grid_cell_hash u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.coord0    (coord0),
		.coord1    (coord1),
		.coord2    (coord2),
		.coord3    (coord3),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.hash_a    (hash_a),
		.hash_b    (hash_b)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	// Output side: takes hash words and stalls in bursts or for one long hold.
	initial begin : hash_sink
		int unsigned stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall)
				hasher.check_hash(hash_a, hash_b);
			if (hold_req) begin
				hold_req = 1'b0;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left != 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				out_stall <= 1'b1;
				stall_left = $urandom_range(1, 12) - 1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	function automatic pgch_pkg::word_t pick_coord();
		case ($urandom_range(0, 4))
			0: return $urandom_range(0, 64) - 32;
			1: return 32'h7fffffff;
			2: return 32'h80000000;
			default: return $urandom;
		endcase
	endfunction

	task automatic push_group(input pgch_pkg::word_t c0, input pgch_pkg::word_t c1,
			input pgch_pkg::word_t c2, input pgch_pkg::word_t c3);
		in_valid <= 1'b1;
		coord0 <= c0;
		coord1 <= c1;
		coord2 <= c2;
		coord3 <= c3;
		offering = 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		hasher.take_group(c0, c1, c2, c3);
		groups_sent++;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			offering = 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	task automatic push_random_group();
		push_group(pick_coord(), pick_coord(), pick_coord(), pick_coord());
	endtask

	// A group that yields no hash word may still be in the rounds when the last
	// hash word is out, so the drain runs past the block's latency.
	task automatic wait_idle();
		if (offering) begin
			in_valid <= 1'b0;
			offering = 1'b0;
		end
		while (hasher.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_dims(input logic [pgch_pkg::DIMS_W-1:0] value);
		cfg_wen <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wen <= 1'b0;
		hasher.set_dims(value);
	endtask

	initial begin : stimulus
		logic [pgch_pkg::DIMS_W-1:0] dims_pick;
		int unsigned eff;
		int unsigned groups;
		int unsigned vectors;
		bit pressed;

		pressed = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset count of four: one group per vector, sum wraps at the extremes.
		push_group(32'h0, 32'h0, 32'h0, 32'h0);
		push_group(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
		push_group(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
		push_group(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
		push_group(32'h1, 32'hffffffff, 32'h2, 32'hfffffffe);

		// A count of zero acts as one, so lanes one to three are dropped.
		wait_idle();
		write_dims('0);
		push_group(32'h5, 32'h7fffffff, 32'h80000000, 32'hffffffff);
		push_group(32'hffffffff, 32'h12345678, 32'h9abcdef0, 32'h1);

		// Counts above the limit are clamped to the limit.
		wait_idle();
		write_dims(5'd31);
		repeat (4) push_random_group();
		wait_idle();
		write_dims(5'd17);
		repeat (4) push_random_group();

		// Count changed in the middle of a vector: the next group closes it.
		wait_idle();
		write_dims(5'd16);
		push_random_group();
		push_random_group();
		wait_idle();
		write_dims(5'd7);
		push_random_group();

		wait_idle();
		write_dims(5'd5);
		push_random_group();
		push_random_group();

		groups_sent = 0;
		while (groups_sent < RANDOM_GROUPS) begin
			if (!pressed && groups_sent >= RANDOM_GROUPS / 2) begin
				// Long output hold with back-to-back input, so the block backs up.
				pressed = 1'b1;
				idle_on = 1'b0;
				wait_idle();
				write_dims(5'd4);
				hold_req = 1'b1;
				repeat (40) push_random_group();
			end
			idle_on = (groups_sent + QUIET_GROUPS < RANDOM_GROUPS) &&
				($urandom_range(0, 3) != 0);
			wait_idle();
			case ($urandom_range(0, 7))
				0: dims_pick = $urandom_range(0, 31);
				1: dims_pick = $urandom_range(0, 1) ? 5'd1 : 5'd16;
				default: dims_pick = $urandom_range(1, 16);
			endcase
			write_dims(dims_pick);
			eff = (dims_pick == 0) ? 1 :
				(dims_pick > pgch_pkg::DIMS_MAX) ? pgch_pkg::DIMS_MAX : dims_pick;
			groups = (eff + 3) / 4;
			vectors = $urandom_range(2, 24);
			repeat (vectors * groups) push_random_group();
			// Sometimes leave a vector open so the next count lands mid-vector.
			if (groups > 1 && $urandom_range(0, 2) == 0)
				repeat ($urandom_range(1, groups - 1)) push_random_group();
		end

		wait_idle();
		if (hasher.mismatches == 0 && hasher.pending() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
